### hw/rtl/twdl_pkg.sv
// Shared types and codes for the two-wire debug link master.
// Holds the request and result item structs and the command codes.
// No dependencies.
package twdl_pkg;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_CTRL  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [15:0] ACK_TIMEOUT_RESET = 16'h0100;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  inst_code;
    logic [15:0] wr_word;
    logic        sda_in;
  } req_t;

  typedef struct packed {
    logic        scl;
    logic        sda_out;
    logic        sda_drive;
    logic        busy_res;
    logic        done_res;
    logic        ok;
    logic [15:0] rd_word;
  } res_t;

endpackage

### hw/rtl/two_wire_debug_link_master_unit.sv
// Two-wire debug link master: one pin step per accepted item.
// Depends on twdl_pkg for the item structs and command codes.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-------------------------
//   in_item  | input     | in_valid / in_ready  | twdl_pkg::req_t
//   out_item | output    | out_valid / out_ready| twdl_pkg::res_t
//   cfg      | input     | cfg_we (no wait)     | cfg_wdata = ack_timeout
//
// Each item is one pin step: the phase sequencer and pin/result logic sit
// between the state and result registers, so one item is accepted per clock
// unless stalled. The result register is the only buffer: in_ready stays
// high while it is empty or being drained this cycle, and drops only while a
// result waits and out_ready is low. Synchronous active-high reset puts the
// sequencer in idle, clears the result valid and reloads ack_timeout to 256.
module two_wire_debug_link_master_unit #(
  parameter int DATA_WIDTH     = 16,
  parameter int INST_WIDTH     = 8,
  parameter int PARITY_SAMPLES = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  twdl_pkg::req_t   in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output twdl_pkg::res_t   out_item,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_wdata
);

  // Shift register covers both the instruction and the data word.
  localparam int SW = (DATA_WIDTH > INST_WIDTH) ? DATA_WIDTH : INST_WIDTH;
  localparam int BW = $clog2(SW + 1);
  localparam logic [SW-1:0] INST_MASK = SW'((64'd1 << INST_WIDTH) - 64'd1);
  localparam logic [SW-1:0] DATA_MASK = SW'((64'd1 << DATA_WIDTH) - 64'd1);

  // Sequencer phases.
  localparam logic [4:0] PH_IDLE  = 5'd0;
  localparam logic [4:0] PH_ST1   = 5'd1;
  localparam logic [4:0] PH_ST2   = 5'd2;
  localparam logic [4:0] PH_I_LO  = 5'd3;
  localparam logic [4:0] PH_I_HI  = 5'd4;
  localparam logic [4:0] PH_I_END = 5'd5;
  localparam logic [4:0] PH_A_LO  = 5'd6;
  localparam logic [4:0] PH_A_HI  = 5'd7;
  localparam logic [4:0] PH_W_LO  = 5'd8;
  localparam logic [4:0] PH_W_HI  = 5'd9;
  localparam logic [4:0] PH_P_LO  = 5'd10;
  localparam logic [4:0] PH_P_HI  = 5'd11;
  localparam logic [4:0] PH_R_LO  = 5'd12;
  localparam logic [4:0] PH_R_HI  = 5'd13;
  localparam logic [4:0] PH_Q_LO  = 5'd14;
  localparam logic [4:0] PH_Q_HI  = 5'd15;
  localparam logic [4:0] PH_S0    = 5'd16;
  localparam logic [4:0] PH_S1    = 5'd17;
  localparam logic [4:0] PH_S2    = 5'd18;

  // Sequencer state.
  logic [4:0]            phase, phase_next;
  logic [1:0]            op_kind, op_kind_next;
  logic [BW-1:0]         bit_index, bit_index_next;
  logic [SW-1:0]         shift_word, shift_word_next;
  logic                  parity_bit, parity_bit_next;
  logic [16:0]           wait_count, wait_count_next;
  logic [1:0]            parity_tries, parity_tries_next;
  logic [DATA_WIDTH-1:0] data_latch, data_latch_next;
  logic                  result_ok, result_ok_next;
  logic [15:0]           ack_timeout;

  twdl_pkg::res_t        res;
  logic                  accept;
  logic [BW-1:0]         bit_index_inc;
  logic [31:0]           word_wide;
  logic                  bit_out;

  assign in_ready      = !out_valid || out_ready;
  assign accept        = in_valid && in_ready;
  assign bit_index_inc = bit_index + BW'(1);
  assign word_wide     = 32'(shift_word & DATA_MASK);

  // One pin step: drive the pins for this tick and advance the phase.
  always_comb begin
    phase_next        = phase;
    op_kind_next      = op_kind;
    bit_index_next    = bit_index;
    shift_word_next   = shift_word;
    parity_bit_next   = parity_bit;
    wait_count_next   = wait_count;
    parity_tries_next = parity_tries;
    data_latch_next   = data_latch;
    result_ok_next    = result_ok;
    bit_out           = 1'b0;

    // Idle bus: clock high, data driven high.
    res.scl       = 1'b1;
    res.sda_out   = 1'b1;
    res.sda_drive = 1'b1;
    res.busy_res  = 1'b1;
    res.done_res  = 1'b0;
    res.ok        = 1'b0;
    res.rd_word   = 16'd0;

    case (phase)
      PH_IDLE: begin
        res.busy_res = 1'b0;
        if (in_item.cmd != twdl_pkg::CMD_TICK) begin
          // Latch the request and open a start condition.
          res.busy_res      = 1'b1;
          op_kind_next      = in_item.cmd;
          data_latch_next   = DATA_WIDTH'(in_item.wr_word);
          shift_word_next   = SW'(in_item.inst_code) & INST_MASK;
          bit_index_next    = '0;
          parity_bit_next   = 1'b0;
          wait_count_next   = '0;
          parity_tries_next = '0;
          result_ok_next    = 1'b0;
          phase_next        = PH_ST1;
        end
      end
      PH_ST1: begin
        res.sda_out = 1'b0;
        phase_next  = PH_ST2;
      end
      PH_ST2: begin
        res.scl     = 1'b0;
        res.sda_out = 1'b0;
        phase_next  = PH_I_LO;
      end
      PH_I_LO: begin
        res.scl     = 1'b0;
        res.sda_out = shift_word[INST_WIDTH-1];
        phase_next  = PH_I_HI;
      end
      PH_I_HI: begin
        res.sda_out     = shift_word[INST_WIDTH-1];
        shift_word_next = (shift_word << 1) & INST_MASK;
        if (bit_index_inc >= BW'(INST_WIDTH)) begin
          bit_index_next = '0;
          phase_next     = PH_I_END;
        end else begin
          bit_index_next = bit_index_inc;
          phase_next     = PH_I_LO;
        end
      end
      PH_I_END: begin
        res.scl     = 1'b0;
        res.sda_out = 1'b0;
        phase_next  = PH_A_LO;
      end
      PH_A_LO: begin
        res.scl         = 1'b0;
        res.sda_out     = 1'b0;
        res.sda_drive   = 1'b0;
        wait_count_next = '0;
        phase_next      = PH_A_HI;
      end
      PH_A_HI: begin
        res.sda_out   = 1'b0;
        res.sda_drive = 1'b0;
        if (!in_item.sda_in) begin
          wait_count_next = '0;
          if (op_kind == twdl_pkg::CMD_WRITE && parity_tries == 2'd0) begin
            // First ack of a write: send the data word next.
            parity_tries_next = 2'd1;
            shift_word_next   = SW'(data_latch);
            bit_index_next    = '0;
            parity_bit_next   = 1'b0;
            phase_next        = PH_W_LO;
          end else if (op_kind == twdl_pkg::CMD_READ) begin
            shift_word_next   = '0;
            bit_index_next    = '0;
            parity_bit_next   = 1'b0;
            parity_tries_next = '0;
            phase_next        = PH_R_LO;
          end else begin
            result_ok_next = 1'b1;
            phase_next     = PH_S0;
          end
        end else if (wait_count >= {1'b0, ack_timeout}) begin
          // No ack in time: drop the transaction with failure.
          shift_word_next = '0;
          result_ok_next  = 1'b0;
          phase_next      = PH_S0;
        end else begin
          wait_count_next = wait_count + 17'd1;
        end
      end
      PH_W_LO: begin
        res.scl     = 1'b0;
        res.sda_out = shift_word[DATA_WIDTH-1];
        phase_next  = PH_W_HI;
      end
      PH_W_HI: begin
        bit_out         = shift_word[DATA_WIDTH-1];
        res.sda_out     = bit_out;
        parity_bit_next = parity_bit ^ bit_out;
        shift_word_next = (shift_word << 1) & DATA_MASK;
        if (bit_index_inc >= BW'(DATA_WIDTH)) begin
          bit_index_next = '0;
          phase_next     = PH_P_LO;
        end else begin
          bit_index_next = bit_index_inc;
          phase_next     = PH_W_LO;
        end
      end
      PH_P_LO: begin
        res.scl     = 1'b0;
        res.sda_out = parity_bit;
        phase_next  = PH_P_HI;
      end
      PH_P_HI: begin
        res.sda_out = parity_bit;
        phase_next  = PH_A_LO;
      end
      PH_R_LO: begin
        res.scl       = 1'b0;
        res.sda_out   = 1'b0;
        res.sda_drive = 1'b0;
        phase_next    = PH_R_HI;
      end
      PH_R_HI: begin
        res.sda_out     = 1'b0;
        res.sda_drive   = 1'b0;
        shift_word_next = ((shift_word << 1) | SW'(in_item.sda_in)) & DATA_MASK;
        parity_bit_next = parity_bit ^ in_item.sda_in;
        if (bit_index_inc >= BW'(DATA_WIDTH)) begin
          bit_index_next = '0;
          phase_next     = PH_Q_LO;
        end else begin
          bit_index_next = bit_index_inc;
          phase_next     = PH_R_LO;
        end
      end
      PH_Q_LO: begin
        res.scl           = 1'b0;
        res.sda_out       = 1'b0;
        res.sda_drive     = 1'b0;
        parity_tries_next = '0;
        phase_next        = PH_Q_HI;
      end
      PH_Q_HI: begin
        res.sda_out   = 1'b0;
        res.sda_drive = 1'b0;
        if (in_item.sda_in == parity_bit) begin
          result_ok_next = 1'b1;
          phase_next     = PH_S0;
        end else begin
          // Resample the parity bit until the sample budget runs out.
          parity_tries_next = parity_tries + 2'd1;
          if (parity_tries_next >= 2'(PARITY_SAMPLES)) begin
            result_ok_next = 1'b0;
            phase_next     = PH_S0;
          end
        end
      end
      PH_S0: begin
        res.scl     = 1'b0;
        res.sda_out = 1'b0;
        phase_next  = PH_S1;
      end
      PH_S1: begin
        res.sda_out = 1'b0;
        phase_next  = PH_S2;
      end
      PH_S2: begin
        // Stop condition completes: report the outcome.
        res.busy_res = 1'b0;
        res.done_res = 1'b1;
        res.ok       = result_ok;
        if (op_kind == twdl_pkg::CMD_READ) begin
          res.rd_word = word_wide[15:0];
        end
        phase_next = PH_IDLE;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // Advance the sequencer only on an accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      op_kind      <= '0;
      bit_index    <= '0;
      shift_word   <= '0;
      parity_bit   <= 1'b0;
      wait_count   <= '0;
      parity_tries <= '0;
      data_latch   <= '0;
      result_ok    <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      op_kind      <= op_kind_next;
      bit_index    <= bit_index_next;
      shift_word   <= shift_word_next;
      parity_bit   <= parity_bit_next;
      wait_count   <= wait_count_next;
      parity_tries <= parity_tries_next;
      data_latch   <= data_latch_next;
      result_ok    <= result_ok_next;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout <= twdl_pkg::ACK_TIMEOUT_RESET;
    end else if (cfg_we) begin
      ack_timeout <= cfg_wdata;
    end
  end

  // Result register: hold until taken, refill in the same cycle it drains.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item <= res;
    end
  end

endmodule

### verif/tb_top.sv
// Self-checking testbench for the two-wire debug link master: sends pin-step items,
// predicts each result from its own model of the link, and checks every result.
// Depends on twdl_pkg and two_wire_debug_link_master_unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_BITS    = 16;
  localparam int INST_BITS    = 8;
  localparam int PARITY_TRIES = 3;
  // A lag that no timeout reaches: the ack never comes.
  localparam int NO_ACK       = 32'h7fff_ffff;
  localparam int MAX_REPORTS  = 100;

  // Link phases, one per pin step of the bus protocol.
  typedef enum logic [4:0] {
    LK_IDLE, LK_START_A, LK_START_B, LK_INST_LO, LK_INST_HI, LK_INST_END,
    LK_ACK_LO, LK_ACK_HI, LK_DATA_LO, LK_DATA_HI, LK_PAR_LO, LK_PAR_HI,
    LK_RD_LO, LK_RD_HI, LK_RPAR_LO, LK_RPAR_HI, LK_STOP_A, LK_STOP_B, LK_STOP_C
  } link_phase_e;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           in_valid  = 1'b0;
  logic           in_ready;
  twdl_pkg::req_t in_item   = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  twdl_pkg::res_t out_item;
  logic           cfg_we    = 1'b0;
  logic [15:0]    cfg_wdata = '0;

  // Predicted link state, advanced once per accepted item.
  link_phase_e lk_phase   = LK_IDLE;
  logic [1:0]  lk_kind    = '0;
  logic [15:0] lk_shift   = '0;
  logic [15:0] lk_data    = '0;
  int          lk_bits    = 0;
  logic        lk_parity  = 1'b0;
  int          lk_wait    = 0;
  int          lk_tries   = 0;
  logic        lk_ok      = 1'b0;
  logic [15:0] lk_timeout = twdl_pkg::ACK_TIMEOUT_RESET;

  // Pin levels and results still owed by the block, oldest first.
  twdl_pkg::res_t pending_pins[$];
  twdl_pkg::res_t want_pins;
  int   mismatches     = 0;
  int   steps_sent     = 0;
  int   results_seen   = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;

  two_wire_debug_link_master_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop: far beyond the slowest legal run under the heaviest stalls.
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Link predictor: advance one pin step and return the pins and result it gives.
  // ---------------------------------------------------------------------------
  function automatic twdl_pkg::res_t advance_link(twdl_pkg::req_t r);
    twdl_pkg::res_t o;
    logic b;
    o = '0;
    o.scl       = 1'b1;
    o.sda_out   = 1'b1;
    o.sda_drive = 1'b1;
    o.busy_res  = 1'b1;
    case (lk_phase)
      LK_IDLE: begin
        // Idle bus: clock high, data driven high. A tick-only request does nothing.
        o.busy_res = 1'b0;
        if (r.cmd != twdl_pkg::CMD_TICK) begin
          o.busy_res = 1'b1;
          lk_kind    = r.cmd;
          lk_shift   = {8'h00, r.inst_code};
          lk_data    = r.wr_word;
          lk_bits    = 0;
          lk_parity  = 1'b0;
          lk_wait    = 0;
          lk_tries   = 0;
          lk_ok      = 1'b0;
          lk_phase   = LK_START_A;
        end
      end
      LK_START_A: begin
        o.sda_out = 1'b0;
        lk_phase  = LK_START_B;
      end
      LK_START_B: begin
        o.scl     = 1'b0;
        o.sda_out = 1'b0;
        lk_phase  = LK_INST_LO;
      end
      LK_INST_LO: begin
        o.scl     = 1'b0;
        o.sda_out = lk_shift[INST_BITS-1];
        lk_phase  = LK_INST_HI;
      end
      LK_INST_HI: begin
        o.sda_out = lk_shift[INST_BITS-1];
        lk_shift  = (lk_shift << 1) & 16'h00ff;
        lk_bits++;
        if (lk_bits >= INST_BITS) begin
          lk_bits  = 0;
          lk_phase = LK_INST_END;
        end else begin
          lk_phase = LK_INST_LO;
        end
      end
      LK_INST_END: begin
        o.scl     = 1'b0;
        o.sda_out = 1'b0;
        lk_phase  = LK_ACK_LO;
      end
      LK_ACK_LO: begin
        o.scl       = 1'b0;
        o.sda_out   = 1'b0;
        o.sda_drive = 1'b0;
        lk_wait     = 0;
        lk_phase    = LK_ACK_HI;
      end
      LK_ACK_HI: begin
        o.sda_out   = 1'b0;
        o.sda_drive = 1'b0;
        if (r.sda_in == 1'b0) begin
          lk_wait = 0;
          if (lk_kind == twdl_pkg::CMD_WRITE && lk_tries == 0) begin
            // First ack of a write: move on to the data word.
            lk_tries  = 1;
            lk_shift  = lk_data;
            lk_bits   = 0;
            lk_parity = 1'b0;
            lk_phase  = LK_DATA_LO;
          end else if (lk_kind == twdl_pkg::CMD_READ) begin
            lk_shift  = '0;
            lk_bits   = 0;
            lk_parity = 1'b0;
            lk_tries  = 0;
            lk_phase  = LK_RD_LO;
          end else begin
            lk_ok    = 1'b1;
            lk_phase = LK_STOP_A;
          end
        end else if (lk_wait >= int'(lk_timeout)) begin
          // Ack timeout: drop whatever was shifted, report failure.
          lk_shift = '0;
          lk_ok    = 1'b0;
          lk_phase = LK_STOP_A;
        end else begin
          lk_wait++;
        end
      end
      LK_DATA_LO: begin
        o.scl     = 1'b0;
        o.sda_out = lk_shift[DATA_BITS-1];
        lk_phase  = LK_DATA_HI;
      end
      LK_DATA_HI: begin
        b         = lk_shift[DATA_BITS-1];
        o.sda_out = b;
        lk_parity = lk_parity ^ b;
        lk_shift  = lk_shift << 1;
        lk_bits++;
        if (lk_bits >= DATA_BITS) begin
          lk_bits  = 0;
          lk_phase = LK_PAR_LO;
        end else begin
          lk_phase = LK_DATA_LO;
        end
      end
      LK_PAR_LO: begin
        o.scl     = 1'b0;
        o.sda_out = lk_parity;
        lk_phase  = LK_PAR_HI;
      end
      LK_PAR_HI: begin
        o.sda_out = lk_parity;
        lk_phase  = LK_ACK_LO;
      end
      LK_RD_LO: begin
        o.scl       = 1'b0;
        o.sda_out   = 1'b0;
        o.sda_drive = 1'b0;
        lk_phase    = LK_RD_HI;
      end
      LK_RD_HI: begin
        o.sda_out   = 1'b0;
        o.sda_drive = 1'b0;
        lk_shift    = {lk_shift[DATA_BITS-2:0], r.sda_in};
        lk_parity   = lk_parity ^ r.sda_in;
        lk_bits++;
        if (lk_bits >= DATA_BITS) begin
          lk_bits  = 0;
          lk_phase = LK_RPAR_LO;
        end else begin
          lk_phase = LK_RD_LO;
        end
      end
      LK_RPAR_LO: begin
        o.scl       = 1'b0;
        o.sda_out   = 1'b0;
        o.sda_drive = 1'b0;
        lk_tries    = 0;
        lk_phase    = LK_RPAR_HI;
      end
      LK_RPAR_HI: begin
        // Sample the parity bit again after each mismatch, up to the limit.
        o.sda_out   = 1'b0;
        o.sda_drive = 1'b0;
        if (r.sda_in == lk_parity) begin
          lk_ok    = 1'b1;
          lk_phase = LK_STOP_A;
        end else begin
          lk_tries++;
          if (lk_tries >= PARITY_TRIES) begin
            lk_ok    = 1'b0;
            lk_phase = LK_STOP_A;
          end
        end
      end
      LK_STOP_A: begin
        o.scl     = 1'b0;
        o.sda_out = 1'b0;
        lk_phase  = LK_STOP_B;
      end
      LK_STOP_B: begin
        o.sda_out = 1'b0;
        lk_phase  = LK_STOP_C;
      end
      default: begin
        // Stop completes: done pulse, read word only for a read.
        o.busy_res = 1'b0;
        o.done_res = 1'b1;
        o.ok       = lk_ok;
        o.rd_word  = (lk_kind == twdl_pkg::CMD_READ) ? lk_shift : 16'h0000;
        lk_phase   = LK_IDLE;
      end
    endcase
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic twdl_pkg::req_t random_req();
    twdl_pkg::req_t r;
    r.cmd       = 2'($urandom_range(3));
    r.inst_code = 8'($urandom_range(255));
    r.wr_word   = 16'($urandom_range(65535));
    r.sda_in    = 1'($urandom_range(1));
    return r;
  endfunction

  // Pick the data-line level a well-behaved target would show in this phase.
  function automatic logic pick_sda(logic [15:0] rword, int lag1, int lag2, int misses);
    int   lag;
    logic s;
    case (lk_phase)
      LK_ACK_HI: begin
        // Second ack of a write uses its own lag; hold high until the lag runs out.
        lag = (lk_kind == twdl_pkg::CMD_WRITE && lk_tries == 1) ? lag2 : lag1;
        s   = (lk_wait >= lag) ? 1'b0 : 1'b1;
      end
      LK_RD_HI:   s = rword[DATA_BITS-1-lk_bits];
      LK_RPAR_HI: s = (lk_tries < misses) ? ~lk_parity : lk_parity;
      default:    s = 1'($urandom_range(1));
    endcase
    return s;
  endfunction

  // Ack lag for the current timeout: mostly in time, sometimes right at or past the limit.
  function automatic int pick_lag();
    int r;
    int top;
    r   = $urandom_range(9);
    top = (lk_timeout < 4) ? int'(lk_timeout) : 4;
    if (lk_timeout <= 20 && r == 0) return int'(lk_timeout) + 1;
    if (lk_timeout <= 20 && r == 1) return int'(lk_timeout);
    return $urandom_range(0, top);
  endfunction

  // Send one item: idle at random, hold valid and payload until accepted, then predict.
  task automatic send_item(input twdl_pkg::req_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= r;
    do @(posedge clk); while (!in_ready);
    pending_pins.push_back(advance_link(r));
    steps_sent++;
  endtask

  // Hold off the sender until every predicted result has been checked.
  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pins.size() != 0) @(posedge clk);
  endtask

  // Step with random levels until the link is back to idle.
  task automatic finish_link();
    while (lk_phase != LK_IDLE) send_item(random_req());
  endtask

  // Write ack_timeout with the link idle and nothing in flight.
  task automatic set_timeout(input logic [15:0] value);
    finish_link();
    wait_drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    lk_timeout = value;
  endtask

  // One transaction from request to done. While busy, requests stay random so the
  // ignore rule is exercised on every phase, the done step included.
  task automatic run_transaction(input logic [1:0] kind, input logic [7:0] inst,
                                 input logic [15:0] wdata, input logic [15:0] rword,
                                 input int lag1, input int lag2, input int misses,
                                 input bit noisy);
    twdl_pkg::req_t r;
    finish_link();
    r           = random_req();
    r.cmd       = kind;
    r.inst_code = inst;
    r.wr_word   = wdata;
    send_item(r);
    while (lk_phase != LK_IDLE) begin
      r        = random_req();
      r.sda_in = pick_sda(rword, lag1, lag2, misses);
      // Broken target: flip the line now and then.
      if (noisy && $urandom_range(9) == 0) r.sda_in = ~r.sda_in;
      send_item(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
    mismatches++;
    // Keep the log short on a badly broken block; keep counting regardless.
    if (mismatches <= MAX_REPORTS)
      $display("%0t: result %0d %s: expected %h, got %h", $time, results_seen, what,
               want, got);
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_pins.size() == 0) begin
        report_mismatch("arrived with none pending", '0, out_item.rd_word);
      end else begin
        want_pins = pending_pins.pop_front();
        if (out_item.scl !== want_pins.scl)
          report_mismatch("scl", want_pins.scl, out_item.scl);
        if (out_item.sda_out !== want_pins.sda_out)
          report_mismatch("sda_out", want_pins.sda_out, out_item.sda_out);
        if (out_item.sda_drive !== want_pins.sda_drive)
          report_mismatch("sda_drive", want_pins.sda_drive, out_item.sda_drive);
        if (out_item.busy_res !== want_pins.busy_res)
          report_mismatch("busy_res", want_pins.busy_res, out_item.busy_res);
        if (out_item.done_res !== want_pins.done_res)
          report_mismatch("done_res", want_pins.done_res, out_item.done_res);
        if (out_item.ok !== want_pins.ok)
          report_mismatch("ok", want_pins.ok, out_item.ok);
        if (out_item.rd_word !== want_pins.rd_word)
          report_mismatch("rd_word", want_pins.rd_word, out_item.rd_word);
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset timeout of 256: ack on the last allowed sample passes, one later fails.
  task automatic test_reset_defaults();
    twdl_pkg::req_t r;
    // Tick-only steps on an idle bus, both data levels.
    for (int i = 0; i < 4; i++) begin
      r        = random_req();
      r.cmd    = twdl_pkg::CMD_TICK;
      r.sda_in = 1'(i);
      send_item(r);
    end
    run_transaction(twdl_pkg::CMD_CTRL, 8'h5a, 16'h0000, 16'h0000, 256, 0, 0, 1'b0);
    run_transaction(twdl_pkg::CMD_CTRL, 8'hc3, 16'h0000, 16'h0000, 257, 0, 0, 1'b0);
  endtask

  // Control transactions with zero timeout: immediate ack passes, a late one fails.
  task automatic test_control_ops();
    set_timeout(16'd0);
    run_transaction(twdl_pkg::CMD_CTRL, 8'hff, 16'h0000, 16'h0000, 0, 0, 0, 1'b0);
    run_transaction(twdl_pkg::CMD_CTRL, 8'h00, 16'hffff, 16'h0000, 1, 0, 0, 1'b0);
  endtask

  // Writes: data extremes, both acks late but in time, then each ack missing.
  task automatic test_write_ops();
    set_timeout(16'd2);
    run_transaction(twdl_pkg::CMD_WRITE, 8'h00, 16'hffff, 16'h0000, 0, 0, 0, 1'b0);
    run_transaction(twdl_pkg::CMD_WRITE, 8'hff, 16'h0000, 16'h0000, 2, 1, 0, 1'b0);
    run_transaction(twdl_pkg::CMD_WRITE, 8'h81, 16'h8001, 16'h0000, 0, NO_ACK, 0, 1'b0);
    run_transaction(twdl_pkg::CMD_WRITE, 8'h7e, 16'h7ffe, 16'h0000, NO_ACK, 0, 0, 1'b0);
  endtask

  // Reads: word extremes, parity right on the first, second and third sample,
  // parity never right (word still reported), and a missing ack (word cleared).
  task automatic test_read_ops();
    run_transaction(twdl_pkg::CMD_READ, 8'h3c, 16'h0000, 16'hffff, 0, 0, 0, 1'b0);
    run_transaction(twdl_pkg::CMD_READ, 8'hc3, 16'hffff, 16'h0000, 1, 0, 0, 1'b0);
    run_transaction(twdl_pkg::CMD_READ, 8'h11, 16'h0000, 16'h8000, 0, 0, 1, 1'b0);
    run_transaction(twdl_pkg::CMD_READ, 8'h22, 16'h0000, 16'h0001, 0, 0, 2, 1'b0);
    run_transaction(twdl_pkg::CMD_READ, 8'h44, 16'h0000, 16'ha5a5, 0, 0, 3, 1'b0);
    run_transaction(twdl_pkg::CMD_READ, 8'h88, 16'h0000, 16'h5a5a, NO_ACK, 0, 0, 1'b0);
  endtask

  // Largest timeout: a long ack wait and a short one both still pass.
  task automatic test_timeout_limits();
    set_timeout(16'hffff);
    run_transaction(twdl_pkg::CMD_CTRL, 8'h96, 16'h0000, 16'h0000, 40, 0, 0, 1'b0);
    run_transaction(twdl_pkg::CMD_READ, 8'h69, 16'h0000, 16'h1234, 5, 0, 0, 1'b0);
  endtask

  // Random transactions under four idling patterns, with noise bursts, hold-offs
  // and timeout changes mixed in.
  task automatic test_random_traffic();
    int         target;
    int         sel;
    int         misses;
    logic [1:0] kind;
    for (int m = 0; m < 4; m++) begin
      case (m)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
          set_timeout(16'd0);
        end
        1: begin
          send_idle_pct = 76; recv_stall_pct = 0;
          set_timeout(16'hffff);
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 76;
          set_timeout(16'($urandom_range(1, 12)));
        end
        default: begin
          send_idle_pct = 38; recv_stall_pct = 38;
          set_timeout(16'($urandom_range(65535)));
        end
      endcase
      target = steps_sent + 150;
      while (steps_sent < target) begin
        sel = $urandom_range(19);
        if (sel == 0) begin
          // Noise: fully random steps, may leave the link mid-transaction.
          repeat ($urandom_range(1, 12)) send_item(random_req());
        end else if (sel == 1) begin
          wait_drain();
        end else if (sel == 2) begin
          set_timeout(16'($urandom_range(9)));
        end else begin
          kind   = 2'($urandom_range(1, 3));
          misses = ($urandom_range(3) == 0) ? $urandom_range(1, PARITY_TRIES) : 0;
          repeat ($urandom_range(2)) send_item('{cmd: twdl_pkg::CMD_TICK,
                                                 inst_code: 8'($urandom_range(255)),
                                                 wr_word: 16'($urandom_range(65535)),
                                                 sda_in: 1'($urandom_range(1))});
          run_transaction(kind, 8'($urandom_range(255)), 16'($urandom_range(65535)),
                          16'($urandom_range(65535)), pick_lag(), pick_lag(), misses,
                          $urandom_range(9) == 0);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_control_ops();
    test_write_ops();
    test_read_ops();
    test_timeout_limits();
    test_random_traffic();

    // Drain, then give the one-deep result register time to show anything stray.
    wait_drain();
    repeat (10) @(posedge clk);
    if (pending_pins.size() != 0)
      report_mismatch("left pending at end", 16'(pending_pins.size()), '0);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
